// ===== src/vno_pkg.sv =====
package vno_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int COS_TABLE_BITS  = 8;
    localparam int MAX_OCTAVES_DEF = 8;

    localparam int COORD_W = 16;
    localparam int DIV_W   = COORD_W + FRAC_BITS;   // quotient width, Q16.F
    localparam int SCALE_W = 16;
    localparam int VAL_W   = FRAC_BITS + 2;         // corner / smoothed / blended value
    localparam int W_W     = FRAC_BITS + 1;         // blend weight and amplitude
    localparam int OUT_W   = 21;
    localparam int MOP_W   = 33;                    // multiplier operand, signed
    localparam int LUT_N   = 1 << COS_TABLE_BITS;

    localparam logic [31:0] HASH_ADD1 = 32'd789221;
    localparam logic [31:0] HASH_ADD2 = 32'd1376312589;

    typedef enum logic [1:0] {
        CFG_SEED  = 2'd0,
        CFG_SCALE = 2'd1,
        CFG_PERS  = 2'd2,
        CFG_OCT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVX, S_DIVY, S_OSET,
        S_H0, S_H1, S_H2, S_H3,
        S_B0, S_B1, S_B2, S_B3, S_B4, S_B5,
        S_DONE
    } t_state;

    typedef logic [W_W-1:0] t_wlut [0:LUT_N-1];

    // (1 - cos(pi*k/N))/2 in Q2.30, Taylor series of cos, for k <= N/2
    function automatic longint half_q30(longint k);
        longint ang;
        longint x2;
        longint r;
        longint q;
        ang = (64'sd3373259426 * k) >>> COS_TABLE_BITS;
        x2  = (ang * ang) >>> 30;
        r   = longint'(1) << 30;
        for (int i = 0; i < 6; i++) begin
            q = (x2 * r) >>> 30;
            case (i)
                0: q = q / 132;
                1: q = q / 90;
                2: q = q / 56;
                3: q = q / 30;
                4: q = q / 12;
                default: q = q / 2;
            endcase
            r = (longint'(1) << 30) - q;
            if (r < 0) r = 0;
        end
        return ((longint'(1) << 30) - r) / 2;
    endfunction

    function automatic t_wlut build_wlut();
        t_wlut  t;
        longint w;
        bit     up;
        for (int k = 0; k < LUT_N; k++) begin
            up = (k > LUT_N / 2);
            w  = half_q30(up ? longint'(LUT_N - k) : longint'(k));
            w  = (w + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            if (up) w = (longint'(1) << FRAC_BITS) - w;
            t[k] = W_W'(w);
        end
        return t;
    endfunction

    localparam t_wlut WLUT = build_wlut();

endpackage

// ===== src/vno_div.sv =====
// restoring divider, one quotient bit per cycle
module vno_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [vno_pkg::DIV_W-1:0] i_dividend,
    input  logic [vno_pkg::SCALE_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [vno_pkg::DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(vno_pkg::DIV_W);
    localparam int SW    = vno_pkg::SCALE_W;

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic [SW-1:0]             r_rem;
    logic [SW-1:0]             r_den;
    logic [vno_pkg::DIV_W-1:0] r_q;

    logic [SW:0]               w_sh;
    logic [SW:0]               w_diff;
    logic                      w_ge;
    logic [SW-1:0]             n_rem;
    logic [vno_pkg::DIV_W-1:0] n_q;

    always_comb begin
        w_sh   = {r_rem, r_q[vno_pkg::DIV_W-1]};
        w_diff = w_sh - {1'b0, r_den};
        w_ge   = (w_sh >= {1'b0, r_den});
        n_rem  = w_ge ? w_diff[SW-1:0] : w_sh[SW-1:0];
        n_q    = {r_q[vno_pkg::DIV_W-2:0], w_ge};
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(vno_pkg::DIV_W - 1));
    assign o_quot = n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_den <= (i_divisor == '0) ? SW'(1) : i_divisor;  // zero scale acts as one
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

endmodule

// ===== src/value_noise_2d_octaves.sv =====
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// input    | i_valid / o_ready  | i_coord_x[15:0], i_coord_y[15:0]
// output   | o_valid / i_ready  | o_noise_value[20:0] signed, o_saturated
// config   | i_cfg_we           | i_cfg_idx[1:0], i_cfg_data[31:0]
//
// One item at a time: division of x then y, then per octave an offset step and 36 hashes
// (states S_H0 to S_H3 on the shared 33x33 multiplier), the blend states S_B0 to S_B5, then unload.
// Reset is synchronous, active low, and restores the register defaults.
// o_ready is high only when idle; a result waiting in the output register
// does not block the next item until that item's result is due.
module value_noise_2d_octaves #(
    parameter int MAX_OCTAVES = vno_pkg::MAX_OCTAVES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [vno_pkg::COORD_W-1:0]        i_coord_x,
    input  logic [vno_pkg::COORD_W-1:0]        i_coord_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [vno_pkg::OUT_W-1:0]   o_noise_value,
    output logic                               o_saturated,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [31:0]                        i_cfg_data
);

    localparam int F     = vno_pkg::FRAC_BITS;
    localparam int VW    = vno_pkg::VAL_W;
    localparam int WW    = vno_pkg::W_W;
    localparam int ACC_W = VW + 4;
    localparam int SUM_W = VW + $clog2(MAX_OCTAVES) + 1;
    localparam int PX_W  = F + 32 + MAX_OCTAVES;
    localparam int MW    = vno_pkg::MOP_W;
    localparam int CB    = vno_pkg::COS_TABLE_BITS;

    vno_pkg::t_state r_state, n_state;

    logic [31:0]                   r_seed;
    logic [15:0]                   r_scale;
    logic [15:0]                   r_pers;
    logic [3:0]                    r_octc;

    logic [vno_pkg::COORD_W-1:0]   r_cy;
    logic [vno_pkg::DIV_W-1:0]     r_bx, r_by;
    logic [31:0]                   r_ix, r_iy;
    logic [WW-1:0]                 r_wx, r_wy;
    logic [4:0]                    r_oct;
    logic [1:0]                    r_pt, r_nbx, r_nby;
    logic [31:0]                   r_n;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [VW-1:0]          r_v [0:3];
    logic signed [VW-1:0]          r_b1;
    logic [WW-1:0]                 r_amp;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [2*MW-1:0]        r_prod;
    logic                          r_ovld;
    logic signed [vno_pkg::OUT_W-1:0] r_noise;
    logic                          r_sat;

    logic                          w_acc_in, w_div_start, w_div_done;
    logic [vno_pkg::DIV_W-1:0]     w_div_dvd, w_quot;
    logic [4:0]                    w_lim;
    logic [PX_W-1:0]               w_px, w_py;
    logic [31:0]                   w_x, w_y, w_m, w_n, w_h;
    logic signed [VW-1:0]          w_corner;
    logic signed [ACC_W-1:0]       n_acc;
    logic [1:0]                    w_wsh;
    logic                          w_nb_last, w_pt_last, w_oct_last, w_unload;
    logic signed [VW-1:0]          w_slice;
    logic signed [VW-1:0]          w_b2, w_val;
    logic signed [MW-1:0]          w_ma, w_mb;
    logic signed [SUM_W-1:0]       w_sat_hi, w_sat_lo;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= 32'd15731;
            r_scale <= 16'd32;
            r_pers  <= 16'd32768;
            r_octc  <= 4'd4;
        end else if (i_cfg_we) begin
            case (vno_pkg::t_cfg_idx'(i_cfg_idx))
                vno_pkg::CFG_SEED:  r_seed  <= i_cfg_data;
                vno_pkg::CFG_SCALE: r_scale <= i_cfg_data[15:0];
                vno_pkg::CFG_PERS:  r_pers  <= i_cfg_data[15:0];
                vno_pkg::CFG_OCT:   r_octc  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign w_acc_in = i_valid && o_ready;
    assign w_lim    = ({1'b0, r_octc} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, r_octc};

    assign w_div_start = w_acc_in || ((r_state == vno_pkg::S_DIVX) && w_div_done);
    assign w_div_dvd   = (r_state == vno_pkg::S_IDLE) ? {i_coord_x, F'(0)} : {r_cy, F'(0)};

    vno_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (r_scale),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // octave position
    assign w_px = PX_W'(r_bx) << r_oct;
    assign w_py = PX_W'(r_by) << r_oct;

    // lattice hash of the current neighbour
    always_comb begin
        w_x = r_ix + 32'(r_pt[0]) + 32'(r_nbx) - 32'd1;
        w_y = r_iy + 32'(r_pt[1]) + 32'(r_nby) - 32'd1;
        w_m = w_x + (w_y << 5) + (w_y << 4) + (w_y << 3) + w_y;   // x + 57*y
        w_n = w_m ^ (w_m << 13);
        w_h = r_prod[31:0] + vno_pkg::HASH_ADD2;
        w_corner = $signed(VW'(1 << F)) - $signed({1'b0, w_h[30:30-F]});
        if (r_nbx == 2'd1 && r_nby == 2'd1)      w_wsh = 2'd2;  // centre
        else if (r_nbx == 2'd1 || r_nby == 2'd1) w_wsh = 2'd1;  // side
        else                                     w_wsh = 2'd0;  // corner
        n_acc      = r_acc + (ACC_W'(w_corner) <<< w_wsh);
        w_nb_last  = (r_nbx == 2'd2) && (r_nby == 2'd2);
        w_pt_last  = (r_pt == 2'd3);
        w_oct_last = ((r_oct + 5'd1) == w_lim);
    end

    assign w_slice = $signed(r_prod[F +: VW]);
    assign w_b2    = r_v[2] + w_slice;
    assign w_val   = r_b1 + w_slice;

    assign w_sat_hi = SUM_W'((1 << (vno_pkg::OUT_W - 1)) - 1);
    assign w_sat_lo = -SUM_W'(1 << (vno_pkg::OUT_W - 1));
    assign w_unload = !r_ovld || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vno_pkg::S_IDLE: if (w_acc_in) n_state = vno_pkg::S_DIVX;
            vno_pkg::S_DIVX: if (w_div_done) n_state = vno_pkg::S_DIVY;
            vno_pkg::S_DIVY: begin
                if (w_div_done) n_state = (w_lim == 5'd0) ? vno_pkg::S_DONE : vno_pkg::S_OSET;
            end
            vno_pkg::S_OSET: n_state = vno_pkg::S_H0;
            vno_pkg::S_H0:   n_state = vno_pkg::S_H1;
            vno_pkg::S_H1:   n_state = vno_pkg::S_H2;
            vno_pkg::S_H2:   n_state = vno_pkg::S_H3;
            vno_pkg::S_H3:   n_state = (w_nb_last && w_pt_last) ? vno_pkg::S_B0 : vno_pkg::S_H0;
            vno_pkg::S_B0:   n_state = vno_pkg::S_B1;
            vno_pkg::S_B1:   n_state = vno_pkg::S_B2;
            vno_pkg::S_B2:   n_state = vno_pkg::S_B3;
            vno_pkg::S_B3:   n_state = vno_pkg::S_B4;
            vno_pkg::S_B4:   n_state = vno_pkg::S_B5;
            vno_pkg::S_B5:   n_state = w_oct_last ? vno_pkg::S_DONE : vno_pkg::S_OSET;
            vno_pkg::S_DONE: if (w_unload) n_state = vno_pkg::S_IDLE;
            default:         n_state = vno_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: ready and multiplier operands
    always_comb begin
        o_ready = (r_state == vno_pkg::S_IDLE);
        w_ma    = '0;
        w_mb    = '0;
        case (r_state)
            vno_pkg::S_H0: begin
                w_ma = {1'b0, w_n};
                w_mb = {1'b0, w_n};
            end
            vno_pkg::S_H1: begin
                w_ma = {1'b0, r_prod[31:0]};
                w_mb = {1'b0, r_seed};
            end
            vno_pkg::S_H2: begin
                w_ma = {1'b0, r_n};
                w_mb = {1'b0, r_prod[31:0] + vno_pkg::HASH_ADD1};
            end
            vno_pkg::S_B0: begin
                w_ma = MW'(r_v[1] - r_v[0]);
                w_mb = MW'({1'b0, r_wx});
            end
            vno_pkg::S_B1: begin
                w_ma = MW'(r_v[3] - r_v[2]);
                w_mb = MW'({1'b0, r_wx});
            end
            vno_pkg::S_B2: begin
                w_ma = MW'(w_b2 - r_b1);
                w_mb = MW'({1'b0, r_wy});
            end
            vno_pkg::S_B3: begin
                w_ma = MW'(w_val);
                w_mb = MW'({1'b0, r_amp});
            end
            vno_pkg::S_B4: begin
                w_ma = MW'({1'b0, r_amp});
                w_mb = MW'({1'b0, r_pers});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vno_pkg::S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == vno_pkg::S_DONE && w_unload) r_ovld <= 1'b1;
            else if (i_ready)                          r_ovld <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            vno_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    r_cy  <= i_coord_y;
                    r_oct <= '0;
                    r_sum <= '0;
                    r_amp <= WW'(1 << F);
                end
            end
            vno_pkg::S_DIVX: if (w_div_done) r_bx <= w_quot;
            vno_pkg::S_DIVY: if (w_div_done) r_by <= w_quot;
            vno_pkg::S_OSET: begin
                r_ix  <= w_px[F +: 32];
                r_iy  <= w_py[F +: 32];
                r_wx  <= vno_pkg::WLUT[w_px[F-1 -: CB]];
                r_wy  <= vno_pkg::WLUT[w_py[F-1 -: CB]];
                r_pt  <= '0;
                r_nbx <= '0;
                r_nby <= '0;
                r_acc <= '0;
            end
            vno_pkg::S_H0: r_n <= w_n;
            vno_pkg::S_H3: begin
                if (r_nbx == 2'd2) begin
                    r_nbx <= '0;
                    r_nby <= (r_nby == 2'd2) ? 2'd0 : r_nby + 2'd1;
                end else begin
                    r_nbx <= r_nbx + 2'd1;
                end
                if (w_nb_last) begin
                    r_v[r_pt] <= VW'(n_acc >>> 4);
                    r_acc     <= '0;
                    r_pt      <= r_pt + 2'd1;
                end else begin
                    r_acc <= n_acc;
                end
            end
            vno_pkg::S_B1: r_b1  <= r_v[0] + w_slice;
            vno_pkg::S_B2: r_b1  <= r_b1;
            vno_pkg::S_B3: r_b1  <= r_b1;
            vno_pkg::S_B4: r_sum <= r_sum + SUM_W'(w_slice);
            vno_pkg::S_B5: begin
                r_amp <= r_prod[16 +: WW];       // persistence is Q0.16
                r_oct <= r_oct + 5'd1;
            end
            vno_pkg::S_DONE: begin
                if (w_unload) begin
                    if (r_sum > w_sat_hi) begin
                        r_noise <= vno_pkg::OUT_W'(w_sat_hi);
                        r_sat   <= 1'b1;
                    end else if (r_sum < w_sat_lo) begin
                        r_noise <= vno_pkg::OUT_W'(w_sat_lo);
                        r_sat   <= 1'b1;
                    end else begin
                        r_noise <= vno_pkg::OUT_W'(r_sum);
                        r_sat   <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_ovld;
    assign o_noise_value = r_noise;
    assign o_saturated   = r_sat;

endmodule

// ===== src/vno_chk.sv =====
module vno_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic [vno_pkg::COORD_W-1:0]      i_coord_x,
    input logic [vno_pkg::COORD_W-1:0]      i_coord_y,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic signed [vno_pkg::OUT_W-1:0] o_noise_value,
    input logic                             o_saturated
);

    // stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_noise_value) && $stable(o_saturated))
        else $error("output item changed while stalled");

    // offered input item holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_coord_x) && $stable(i_coord_y))
        else $error("input item changed while waiting");

    // clipped item sits at a range limit
    a_sat_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_noise_value == 21'sh0FFFFF) || (o_noise_value == 21'sh100000))
        else $error("saturated item not at a limit");

    // one item in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready straight after accepting an item");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("not empty after reset");

endmodule

bind value_noise_2d_octaves vno_chk u_vno_chk (.*);
